### rtl/core/utf8s_pkg.sv
`timescale 1ns / 1ps

package utf8s_pkg;

    // Number of classified beats that can wait between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Lead byte length codes.
    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_ASCII   = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    // Bytes of U+FFFD in UTF-8.
    localparam logic [7:0] REPL_BYTE0 = 8'hEF;
    localparam logic [7:0] REPL_BYTE1 = 8'hBF;
    localparam logic [7:0] REPL_BYTE2 = 8'hBD;

    // One output burst: an optional replacement, up to four passed bytes,
    // and another optional replacement, in that order.
    typedef struct packed {
        logic            pre_repl;
        logic            post_repl;
        logic [2:0]      data_count;
        logic [3:0][7:0] data;
        logic            text_last;
    } t_job;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80) begin
            len = LEN_ASCII;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            len = LEN_TWO;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            len = LEN_THREE;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            len = LEN_FOUR;
        end else begin
            len = LEN_INVALID;
        end
        return len;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0: begin
                v = REPL_BYTE0;
            end
            2'd1: begin
                v = REPL_BYTE1;
            end
            default: begin
                v = REPL_BYTE2;
            end
        endcase
        return v;
    endfunction

endpackage

### rtl/core/utf8s_front.sv
`timescale 1ns / 1ps

module utf8s_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_text_last,
    input  logic              i_full,
    output logic              o_push,
    output utf8s_pkg::t_job   o_job
);

    logic [7:0] r_held [3];
    logic [1:0] r_held_count;
    logic [2:0] r_seq_len;
    logic [1:0] n_held_count;
    logic [2:0] n_seq_len;

    logic            accept;
    logic [2:0]      lead;
    logic [7:0]      lo;
    logic [7:0]      hi;
    logic            cont_ok;
    logic            fresh;
    logic            store;
    logic [1:0]      store_idx;
    utf8s_pkg::t_job job;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign lead       = utf8s_pkg::lead_length(i_in_byte);

    // Second-byte ranges narrowed by the lead byte (Unicode table 3-7).
    always_comb begin
        lo = 8'h80;
        hi = 8'hBF;
        if (r_held_count == 2'd1) begin
            case (r_held[0])
                8'hE0: begin
                    lo = 8'hA0;
                end
                8'hED: begin
                    hi = 8'h9F;
                end
                8'hF0: begin
                    lo = 8'h90;
                end
                8'hF4: begin
                    hi = 8'h8F;
                end
                default: begin
                    lo = 8'h80;
                end
            endcase
        end
        cont_ok = (i_in_byte >= lo) && (i_in_byte <= hi);
    end

    always_comb begin
        job            = '0;
        job.data       = {8'h00, r_held[2], r_held[1], r_held[0]};
        job.text_last  = i_text_last;
        n_held_count   = r_held_count;
        n_seq_len      = r_seq_len;
        fresh          = 1'b0;
        store          = 1'b0;
        store_idx      = r_held_count;

        if (r_held_count != 2'd0) begin
            if (cont_ok) begin
                if ({1'b0, r_held_count} + 3'd1 == r_seq_len) begin
                    job.data_count          = {1'b0, r_held_count} + 3'd1;
                    job.data[r_held_count]  = i_in_byte;
                    n_held_count            = 2'd0;
                    n_seq_len               = 3'd0;
                end else if (r_held_count < 2'd3) begin
                    store        = 1'b1;
                    n_held_count = r_held_count + 2'd1;
                end
            end else begin
                job.pre_repl = 1'b1;
                n_held_count = 2'd0;
                n_seq_len    = 3'd0;
                fresh        = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        if (fresh) begin
            store_idx = 2'd0;
            case (lead)
                utf8s_pkg::LEN_ASCII: begin
                    job.data[0]    = i_in_byte;
                    job.data_count = 3'd1;
                end
                utf8s_pkg::LEN_INVALID: begin
                    job.post_repl = 1'b1;
                end
                default: begin
                    store        = 1'b1;
                    n_held_count = 2'd1;
                    n_seq_len    = lead;
                end
            endcase
        end

        // Text ends inside a sequence: the held part becomes one replacement.
        if (i_text_last && n_held_count != 2'd0) begin
            job.post_repl = 1'b1;
            n_held_count  = 2'd0;
            n_seq_len     = 3'd0;
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.pre_repl || job.post_repl || job.data_count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_seq_len    <= 3'd0;
        end else if (accept) begin
            r_held_count <= n_held_count;
            r_seq_len    <= n_seq_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_held[store_idx] <= i_in_byte;
        end
    end

    a_held_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count != 2'd0 |-> {1'b0, r_held_count} < r_seq_len)
        else $error("held byte count not below announced sequence length");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_text_last |=> r_held_count == 2'd0)
        else $error("bytes still held after end of text");

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_text_last |-> o_push)
        else $error("end of text produced no output beat");

endmodule

### rtl/core/utf8s_queue.sv
`timescale 1ns / 1ps

module utf8s_queue #(
    parameter int DEPTH = utf8s_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8s_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output utf8s_pkg::t_job   o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    utf8s_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop) && !(i_pop && !o_valid))
        else $error("queue overflow or underflow");

endmodule

### rtl/core/utf8s_back.sv
`timescale 1ns / 1ps

module utf8s_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  utf8s_pkg::t_job   i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_is_replacement,
    output logic              o_run_last,
    output logic              o_text_end
);

    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_is_repl;
    logic       r_run_last;
    logic       r_text_end;

    logic [3:0] pre_len;
    logic [3:0] len;
    logic [3:0] off;
    logic [3:0] tail;
    logic [7:0] cur_byte;
    logic       cur_repl;
    logic       last_byte;
    logic       load;

    always_comb begin
        pre_len = i_job.pre_repl ? 4'd3 : 4'd0;
        len     = pre_len + {1'b0, i_job.data_count} + (i_job.post_repl ? 4'd3 : 4'd0);
        off     = {1'b0, r_idx} - pre_len;
        tail    = off - {1'b0, i_job.data_count};
        if (i_job.pre_repl && r_idx < 3'd3) begin
            cur_byte = utf8s_pkg::repl_byte(r_idx[1:0]);
            cur_repl = 1'b1;
        end else if (off < {1'b0, i_job.data_count}) begin
            cur_byte = i_job.data[off[1:0]];
            cur_repl = 1'b0;
        end else begin
            cur_byte = utf8s_pkg::repl_byte(tail[1:0]);
            cur_repl = 1'b1;
        end
        last_byte = ({1'b0, r_idx} == len - 4'd1);
    end

    assign load  = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = load && last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= last_byte ? 3'd0 : r_idx + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_is_repl  <= cur_repl;
            r_run_last <= last_byte;
            r_text_end <= last_byte && i_job.text_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_is_replacement = r_is_repl;
    assign o_run_last       = r_run_last;
    assign o_text_end       = r_text_end;

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> {1'b0, r_idx} < len)
        else $error("burst position beyond burst length");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_text_end |-> o_run_last)
        else $error("end of text on a beat that does not close its run");

endmodule

### rtl/core/utf8_sanitizer.sv
`timescale 1ns / 1ps

// UTF-8 sanitizer. Raw text enters one byte per beat on the input channel
// (i_in_valid / o_in_stall, with i_text_last on the final byte of a text).
// Sanitized UTF-8 leaves one byte per beat on the output channel
// (o_out_valid / i_out_stall). Well-formed sequences pass unchanged; every
// ill-formed maximal subpart becomes the three bytes EF BF BD, flagged by
// o_is_replacement. o_run_last marks the last byte caused by one input byte
// and o_text_end the last byte of the whole text.
// The front decodes and holds partial sequences, then queues one burst of
// one to six bytes per input byte that yields output; the back plays a
// burst out of the queue one byte per cycle, unless the output stalls,
// through the output register, which follows the queue. Plain text flows
// at one byte per cycle while the output does not stall; a burst of n
// bytes takes n output beats. A stalled output byte holds in the output
// register while the front keeps taking input; the input stalls only once
// the queue (QUEUE_DEPTH bursts) fills. Reset (synchronous, active low)
// empties the queue, drops any partial sequence and clears the output valid.

module utf8_sanitizer #(
    parameter int QUEUE_DEPTH = utf8s_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_text_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_replacement,
    output logic       o_run_last,
    output logic       o_text_end
);

    // Front to queue: one classified burst per accepted byte, when non-empty.
    logic            push;
    logic            full;
    utf8s_pkg::t_job push_job;

    // Queue to back.
    logic            pop;
    logic            head_valid;
    utf8s_pkg::t_job head_job;

    utf8s_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_text_last (i_text_last),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // The queue lets the front keep decoding while the back emits a burst.
    utf8s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    utf8s_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (head_valid),
        .i_job            (head_job),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_is_replacement (o_is_replacement),
        .o_run_last       (o_run_last),
        .o_text_end       (o_text_end)
    );

endmodule
